// ===== hw/rtl/abkf_pkg.sv =====
// Package for the angle/bias Kalman filter unit.
// Holds widths, register indexes, sequencer codes and saturation helpers.
// No dependencies.
package abkf_pkg;

   localparam int ANGLE_W = 32;
   localparam int DT_W    = 16;
   localparam int NOISE_W = 24;
   localparam int COV_W   = 48;
   localparam int GAIN_W  = 32;
   localparam int MUL_A_W = 48;
   localparam int MUL_B_W = 32;
   localparam int MUL_R_W = 58;
   localparam int WIDE_W  = 60;
   localparam int DEN_W   = 49;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [NOISE_W-1:0] Q_ANGLE_RESET    = 24'd16777;
   localparam logic [NOISE_W-1:0] Q_BIAS_RESET     = 24'd50332;
   localparam logic [NOISE_W-1:0] MEAS_NOISE_RESET = 24'd503316;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_Q_ANGLE     = 2'd0,
      CSR_Q_BIAS      = 2'd1,
      CSR_MEAS_NOISE  = 2'd2,
      CSR_START_ANGLE = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      OP_RATE, OP_D11, OP_T, OP_QB, OP_ANG, OP_BIAS,
      OP_P10, OP_P11, OP_P00, OP_P01
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ISSUE, ST_MUL, ST_DIV, ST_DIVWAIT, ST_OUT
   } state_type;

   function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'(64'sd2147483647);
      lo = -hi - WIDE_W'(1);
      if (v > hi) begin
         sat32 = hi[ANGLE_W-1:0];
      end else if (v < lo) begin
         sat32 = lo[ANGLE_W-1:0];
      end else begin
         sat32 = v[ANGLE_W-1:0];
      end
   endfunction

   function automatic logic signed [COV_W-1:0] sat48(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'(64'sd140737488355327);
      lo = -hi - WIDE_W'(1);
      if (v > hi) begin
         sat48 = hi[COV_W-1:0];
      end else if (v < lo) begin
         sat48 = lo[COV_W-1:0];
      end else begin
         sat48 = v[COV_W-1:0];
      end
   endfunction

endpackage

// ===== hw/rtl/abkf_ifs.sv =====
// Valid/ready channel interfaces for the angle/bias Kalman filter unit.
// Depends on abkf_pkg for field widths.
interface abkf_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [abkf_pkg::ANGLE_W-1:0]   measured_angle;
   logic signed [abkf_pkg::ANGLE_W-1:0]   measured_rate;
   logic        [abkf_pkg::DT_W-1:0]      time_step;
   modport source (output valid, measured_angle, measured_rate, time_step, input ready);
   modport sink (input valid, measured_angle, measured_rate, time_step, output ready);
endinterface

interface abkf_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [abkf_pkg::ANGLE_W-1:0]   angle_estimate;
   logic signed [abkf_pkg::ANGLE_W-1:0]   unbiased_rate;
   modport source (output valid, angle_estimate, unbiased_rate, input ready);
   modport sink (input valid, angle_estimate, unbiased_rate, output ready);
endinterface

// ===== hw/rtl/abkf_mul.sv =====
// Shared multiply unit: rounded signed product shifted right by 16 or 24.
// Splits the 48 x 32 magnitude product into two 24 x 32 partial products; depends on abkf_pkg.
module abkf_mul (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [abkf_pkg::MUL_A_W-1:0]   op_a,
   input  logic signed [abkf_pkg::MUL_B_W-1:0]   op_b,
   input  logic                                  shift24,
   output logic                                  done,
   output logic signed [abkf_pkg::MUL_R_W-1:0]   result
);
   import abkf_pkg::*;

   localparam int HALF_W = MUL_A_W / 2;
   localparam int ACC_W  = MUL_A_W + MUL_B_W + 1;

   logic [1:0]               cnt_ff, cnt_in;
   logic [MUL_A_W-1:0]       ma_ff;
   logic [MUL_B_W-1:0]       mb_ff;
   logic                     neg_ff, sel_ff;
   logic [ACC_W-1:0]         acc_ff;
   logic                     done_ff;
   logic signed [MUL_R_W-1:0] result_ff;
   logic signed [MUL_A_W:0]  a_ext;
   logic signed [MUL_B_W:0]  b_ext;
   logic [MUL_A_W:0]         a_mag;
   logic [MUL_B_W:0]         b_mag;
   logic [ACC_W-1:0]         rounded;
   logic [MUL_R_W-2:0]       mag_r;

   assign a_ext = {op_a[MUL_A_W-1], op_a};
   assign b_ext = {op_b[MUL_B_W-1], op_b};
   assign a_mag = a_ext[MUL_A_W] ? (MUL_A_W+1)'(-a_ext) : a_ext;
   assign b_mag = b_ext[MUL_B_W] ? (MUL_B_W+1)'(-b_ext) : b_ext;

   always_comb begin
      if (sel_ff) begin
         rounded = (acc_ff + (ACC_W'(1) << 23)) >> 24;
      end else begin
         rounded = (acc_ff + (ACC_W'(1) << 15)) >> 16;
      end
      mag_r = rounded[MUL_R_W-2:0];
      cnt_in = cnt_ff;
      if (start) begin
         cnt_in = 2'd1;
      end else if (cnt_ff != 2'd0) begin
         cnt_in = cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 2'd0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= (cnt_ff == 2'd3);
      end
      if (start) begin
         ma_ff  <= a_mag[MUL_A_W-1:0];
         mb_ff  <= b_mag[MUL_B_W-1:0];
         neg_ff <= op_a[MUL_A_W-1] ^ op_b[MUL_B_W-1];
         sel_ff <= shift24;
      end
      if (cnt_ff == 2'd1) begin
         acc_ff <= ACC_W'(ma_ff[HALF_W-1:0] * mb_ff);
      end else if (cnt_ff == 2'd2) begin
         acc_ff <= acc_ff + (ACC_W'(ma_ff[MUL_A_W-1:HALF_W] * mb_ff) << HALF_W);
      end
      if (cnt_ff == 2'd3) begin
         result_ff <= neg_ff ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
      end
   end

   assign done   = done_ff;
   assign result = result_ff;
endmodule

// ===== hw/rtl/abkf_div.sv =====
// Gain divider: num / den as signed Q7.24, truncated, magnitude saturated.
// Restoring division, one quotient bit per cycle; depends on abkf_pkg.
module abkf_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [abkf_pkg::COV_W-1:0]     num,
   input  logic signed [abkf_pkg::DEN_W-1:0]     den,
   output logic                                  done,
   output logic signed [abkf_pkg::GAIN_W-1:0]    quotient
);
   import abkf_pkg::*;

   localparam int QBITS = GAIN_W - 1;
   localparam int CNT_W = $clog2(QBITS + 1);
   localparam int INT_BITS = 7;

   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DEN_W-1:0]    d_ff, rem_ff;
   logic [QBITS-1:0]    bits_ff, q_ff;
   logic                neg_ff, zero_ff, ovf_ff, done_ff;
   logic [COV_W:0]      n_full;
   logic [DEN_W:0]      d_full;
   logic [COV_W-1:0]    n_mag;
   logic [DEN_W-1:0]    d_mag;
   logic [DEN_W:0]      trial;
   logic [QBITS-1:0]    m;

   assign n_full = num[COV_W-1] ? (COV_W+1)'(-$signed({num[COV_W-1], num})) : {1'b0, num};
   assign d_full = den[DEN_W-1] ? (DEN_W+1)'(-$signed({den[DEN_W-1], den})) : {1'b0, den};
   assign n_mag  = n_full[COV_W-1:0];
   assign d_mag  = d_full[DEN_W-1:0];
   assign trial  = {rem_ff, bits_ff[QBITS-1]};

   always_comb begin
      cnt_in = cnt_ff;
      if (start) begin
         cnt_in = CNT_W'(QBITS);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
      if (zero_ff) begin
         m = '0;
      end else if (ovf_ff) begin
         m = '1;
      end else begin
         m = q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= (cnt_ff == CNT_W'(1));
      end
      if (start) begin
         d_ff    <= d_mag;
         neg_ff  <= num[COV_W-1] ^ den[DEN_W-1];
         zero_ff <= (d_mag == '0);
         ovf_ff  <= ((COV_W+INT_BITS+2)'(n_mag) >= ((COV_W+INT_BITS+2)'(d_mag) << INT_BITS));
         rem_ff  <= DEN_W'(n_mag >> INT_BITS);
         bits_ff <= {n_mag[INT_BITS-1:0], (QBITS-INT_BITS)'(0)};
         q_ff    <= '0;
      end else if (cnt_ff != '0) begin
         bits_ff <= {bits_ff[QBITS-2:0], 1'b0};
         if (trial >= {1'b0, d_ff}) begin
            rem_ff <= DEN_W'(trial - {1'b0, d_ff});
            q_ff   <= {q_ff[QBITS-2:0], 1'b1};
         end else begin
            rem_ff <= trial[DEN_W-1:0];
            q_ff   <= {q_ff[QBITS-2:0], 1'b0};
         end
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed({1'b0, m}) : $signed({1'b0, m});
endmodule

// ===== hw/rtl/angle_bias_kalman_filter_unit.sv =====
// Top level of the angle/bias Kalman filter unit.
// Sequencer, state and CSR registers; uses abkf_pkg, abkf_ifs, abkf_mul, abkf_div.
//
// Usage:
//   req_chan carries one sample (measured angle, measured rate, time step);
//   rsp_chan returns one transaction per sample (angle estimate, unbiased
//   rate). A transaction moves when valid and ready are both high.
//   csr_* writes q_angle, q_bias, the measurement noise and start_angle by
//   index; a start_angle write also loads the angle state. Write only while idle.
// Sequence:
//   Ten products go through the shared multiplier, each with its own issue
//   step; the two gain divisions run side by side, one quotient bit per
//   cycle; an output step and a return to idle close each sample.
//   req_chan.ready is high only while the sequencer is idle.
// Reset:
//   Synchronous, active high. Clears angle, bias and covariance state and
//   loads the default noise terms.
// Stall:
//   The result sits in an output register; a new sample is accepted while it
//   waits. The next result holds in the sequencer until the register frees.
module angle_bias_kalman_filter_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   abkf_req_if.sink                             req_chan,
   abkf_rsp_if.source                           rsp_chan,
   input  logic                                 csr_write_enable,
   input  logic [abkf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [abkf_pkg::CSR_DATA_W-1:0]      csr_write_data
);
   import abkf_pkg::*;

   state_type                  state_ff, state_in;
   op_type                     op_ff, op_in;
   logic                       mul_start, div_start;

   logic [NOISE_W-1:0]         q_angle_ff, q_bias_ff, meas_noise_ff;
   logic signed [ANGLE_W-1:0]  angle_ff, bias_ff, rate_ff, meas_ff, y_ff;
   logic [DT_W-1:0]            dt_ff;
   logic signed [COV_W-1:0]    p00_ff, p01_ff, p10_ff, p11_ff, t_ff;
   logic signed [GAIN_W-1:0]   k0_ff, k1_ff;
   logic                       rsp_valid_ff;
   logic signed [ANGLE_W-1:0]  rsp_angle_ff, rsp_rate_ff;

   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic                       mul_sel;
   logic                       mul_done;
   logic signed [MUL_R_W-1:0]  mul_res;
   logic signed [WIDE_W-1:0]   m_w;
   logic signed [DEN_W-1:0]    s_val;
   logic                       div0_done, div1_done, div_done;
   logic signed [GAIN_W-1:0]   div0_q, div1_q;
   logic                       accept, rsp_free;

   assign accept   = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign div_done = div0_done && div1_done;
   assign m_w      = WIDE_W'(mul_res);
   assign s_val    = DEN_W'(p00_ff) + $signed({(DEN_W-NOISE_W)'(0), meas_noise_ff});

   always_comb begin
      mul_a   = '0;
      mul_b   = $signed({(MUL_B_W-DT_W)'(0), dt_ff});
      mul_sel = 1'b0;
      case (op_ff)
         OP_RATE: mul_a = MUL_A_W'(rate_ff);
         OP_D11:  mul_a = p11_ff;
         OP_T:    mul_a = t_ff;
         OP_QB:   mul_a = $signed({(MUL_A_W-NOISE_W)'(0), q_bias_ff});
         OP_ANG: begin
            mul_a = MUL_A_W'(y_ff); mul_b = k0_ff; mul_sel = 1'b1;
         end
         OP_BIAS: begin
            mul_a = MUL_A_W'(y_ff); mul_b = k1_ff; mul_sel = 1'b1;
         end
         OP_P10: begin
            mul_a = p00_ff; mul_b = k1_ff; mul_sel = 1'b1;
         end
         OP_P11: begin
            mul_a = p01_ff; mul_b = k1_ff; mul_sel = 1'b1;
         end
         OP_P00: begin
            mul_a = p00_ff; mul_b = k0_ff; mul_sel = 1'b1;
         end
         OP_P01: begin
            mul_a = p01_ff; mul_b = k0_ff; mul_sel = 1'b1;
         end
         default: mul_a = '0;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      mul_start = 1'b0;
      div_start = 1'b0;
      req_chan.ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_ISSUE;
               op_in    = OP_RATE;
            end
         end
         ST_ISSUE: begin
            mul_start = 1'b1;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            if (mul_done) begin
               case (op_ff)
                  OP_QB:  state_in = ST_DIV;
                  OP_P01: state_in = ST_OUT;
                  default: begin
                     state_in = ST_ISSUE;
                     op_in    = op_type'(op_ff + 4'd1);
                  end
               endcase
            end
         end
         ST_DIV: begin
            div_start = 1'b1;
            state_in  = ST_DIVWAIT;
         end
         ST_DIVWAIT: begin
            if (div_done) begin
               state_in = ST_ISSUE;
               op_in    = OP_ANG;
            end
         end
         ST_OUT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_RATE;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_angle_ff    <= Q_ANGLE_RESET;
         q_bias_ff     <= Q_BIAS_RESET;
         meas_noise_ff <= MEAS_NOISE_RESET;
         angle_ff      <= '0;
         bias_ff       <= '0;
         p00_ff        <= '0;
         p01_ff        <= '0;
         p10_ff        <= '0;
         p11_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_Q_ANGLE:     q_angle_ff    <= csr_write_data[NOISE_W-1:0];
               CSR_Q_BIAS:      q_bias_ff     <= csr_write_data[NOISE_W-1:0];
               CSR_MEAS_NOISE:  meas_noise_ff <= csr_write_data[NOISE_W-1:0];
               CSR_START_ANGLE: angle_ff      <= $signed(csr_write_data[ANGLE_W-1:0]);
               default:         q_angle_ff    <= q_angle_ff;
            endcase
         end
         if (state_ff == ST_MUL && mul_done) begin
            case (op_ff)
               OP_RATE: angle_ff <= sat32(WIDE_W'(angle_ff) + m_w);
               OP_D11: begin
                  t_ff   <= sat48(m_w - WIDE_W'(p01_ff) - WIDE_W'(p10_ff)
                                  + $signed({(WIDE_W-NOISE_W)'(0), q_angle_ff}));
                  p01_ff <= sat48(WIDE_W'(p01_ff) - m_w);
                  p10_ff <= sat48(WIDE_W'(p10_ff) - m_w);
               end
               OP_T:    p00_ff  <= sat48(WIDE_W'(p00_ff) + m_w);
               OP_QB:   p11_ff  <= sat48(WIDE_W'(p11_ff) + m_w);
               OP_ANG:  angle_ff <= sat32(WIDE_W'(angle_ff) + m_w);
               OP_BIAS: bias_ff <= sat32(WIDE_W'(bias_ff) + m_w);
               OP_P10:  p10_ff  <= sat48(WIDE_W'(p10_ff) - m_w);
               OP_P11:  p11_ff  <= sat48(WIDE_W'(p11_ff) - m_w);
               OP_P00:  p00_ff  <= sat48(WIDE_W'(p00_ff) - m_w);
               OP_P01:  p01_ff  <= sat48(WIDE_W'(p01_ff) - m_w);
               default: p01_ff  <= p01_ff;
            endcase
         end
         if (state_ff == ST_OUT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         rate_ff <= sat32(WIDE_W'(req_chan.measured_rate) - WIDE_W'(bias_ff));
         meas_ff <= req_chan.measured_angle;
         dt_ff   <= req_chan.time_step;
      end
      if (state_ff == ST_DIVWAIT && div_done) begin
         k0_ff <= div0_q;
         k1_ff <= div1_q;
         y_ff  <= sat32(WIDE_W'(meas_ff) - WIDE_W'(angle_ff));
      end
      if (state_ff == ST_OUT && rsp_free) begin
         rsp_angle_ff <= angle_ff;
         rsp_rate_ff  <= rate_ff;
      end
   end

   abkf_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .shift24 (mul_sel),
      .done    (mul_done),
      .result  (mul_res)
   );

   abkf_div u_div_k0 (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (p00_ff),
      .den      (s_val),
      .done     (div0_done),
      .quotient (div0_q)
   );

   abkf_div u_div_k1 (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (p10_ff),
      .den      (s_val),
      .done     (div1_done),
      .quotient (div1_q)
   );

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.angle_estimate = rsp_angle_ff;
   assign rsp_chan.unbiased_rate  = rsp_rate_ff;
endmodule
